// ===== sv/pwl_pkg.sv =====
`default_nettype none
package pwl_pkg;

    localparam int DEF_ROWS        = 256;
    localparam int DEF_COLUMNS     = 256;
    localparam int DEF_HISTORY_LEN = 16;
    localparam int DEF_THREADS     = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [11:0] THR_RESET = 12'd44;
    localparam logic signed [7:0] W_MIN = -8'sd128;
    localparam logic signed [7:0] W_MAX = 8'sd127;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_UNCOND = 3'd1;
    localparam logic [2:0] KIND_UPDATE = 3'd2;
    localparam logic [2:0] KIND_SQUASH = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_UNCOND,
        OP_UPDATE,
        OP_SQUASH,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  thread;
        logic [31:0] pc;
        logic        resolved_taken;
        logic        was_mispredicted;
        logic [15:0] ckpt_history;
        logic [3:0]  ckpt_head;
        logic [7:0]  ckpt_addr;
    } item_t;

    typedef struct packed {
        logic        taken;
        logic [15:0] history;
        logic [3:0]  head;
        logic [7:0]  addr;
    } res_t;

endpackage
`default_nettype wire

// ===== sv/pwl_ram.sv =====
`default_nettype none
module pwl_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/pwl_fifo.sv =====
`default_nettype none
module pwl_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic      [W-1:0] dout,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  data_reg [DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign dout    = data_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ===== sv/pwl_front.sv =====
`default_nettype none
module pwl_front #(
    parameter int THREADS = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [2:0]    kind,
    input  wire logic [1:0]    thread,
    input  wire logic [31:0]   pc,
    input  wire logic          resolved_taken,
    input  wire logic          was_mispredicted,
    input  wire logic [15:0]   ckpt_history_in,
    input  wire logic [3:0]    ckpt_head_in,
    input  wire logic [7:0]    ckpt_addr_in,
    output logic               full,
    input  wire logic          pop,
    output pwl_pkg::item_t     item,
    output logic               empty
);
    import pwl_pkg::*;

    op_t   op_c;
    item_t item_c;
    logic  [$bits(item_t)-1:0] q_dout;

    // Kinds outside the list and threads beyond the configured count become no-ops that return an all-zero result.
    always_comb
    begin
        unique case (kind)
            KIND_LOOKUP: op_c = OP_LOOKUP;
            KIND_UNCOND: op_c = OP_UNCOND;
            KIND_UPDATE: op_c = OP_UPDATE;
            KIND_SQUASH: op_c = OP_SQUASH;
            KIND_CLEAR:  op_c = OP_CLEAR;
            default:     op_c = OP_NOP;
        endcase
        if (32'(thread) >= THREADS)
        begin
            op_c = OP_NOP;
        end
        item_c.op               = op_c;
        item_c.thread           = thread;
        item_c.pc               = pc;
        item_c.resolved_taken   = resolved_taken;
        item_c.was_mispredicted = was_mispredicted;
        item_c.ckpt_history     = ckpt_history_in;
        item_c.ckpt_head        = ckpt_head_in;
        item_c.ckpt_addr        = ckpt_addr_in;
    end

    pwl_fifo #(.W($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item_c),
        .full  (full),
        .pop   (pop),
        .dout  (q_dout),
        .empty (empty)
    );

    assign item = item_t'(q_dout);

endmodule
`default_nettype wire

// ===== sv/pwl_back.sv =====
`default_nettype none
module pwl_back #(
    parameter int ROWS        = 256,
    parameter int COLUMNS     = 256,
    parameter int HISTORY_LEN = 16,
    parameter int THREADS     = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [11:0]   cfg_wdata,
    input  wire logic          fq_empty,
    input  wire pwl_pkg::item_t fq_item,
    output logic               fq_pop,
    input  wire logic          rq_space,
    output logic               res_push,
    output pwl_pkg::res_t      res_data,
    output logic               clearing
);
    import pwl_pkg::*;

    localparam int HL    = HISTORY_LEN;
    localparam int NB    = HL + 1;
    localparam int NP    = 1 << $clog2(NB);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int RB    = $clog2(ROWS);
    localparam int CB    = $clog2(COLUMNS);
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = $clog2(HL);
    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SW    = $clog2(NB * 128) + 2;
    localparam int CMPW  = (SW > 13) ? SW : 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_SUM,
        S_FIN
    } state_t;

    state_t              st_reg;
    logic                clr_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [11:0]         thr_reg;
    logic [HL-1:0]       hist_reg [THREADS];
    logic [HW-1:0]       head_reg [THREADS];
    logic [7:0]          ring_reg [THREADS][HL];

    item_t               it_reg;
    logic [TW-1:0]       tidx_reg;
    logic [RB-1:0]       row_reg;
    logic [AW-1:0]       addr_reg [NB];
    logic [HL-1:0]       hbits_reg;
    logic signed [SW-1:0] sum_reg;

    logic [AW-1:0]       raddr_c [NB];
    logic [7:0]          rdata [NB];
    logic [7:0]          nudged_c [NB];
    logic                bank_we [NB];
    logic [AW-1:0]       bank_waddr [NB];
    logic [7:0]          bank_wdata [NB];
    logic signed [SW-1:0] sum_tree [1:2*NP-1];

    logic [HL-1:0]       hist_cur;
    logic [HW-1:0]       head_cur;
    logic [HW-1:0]       head_inc;
    logic [HW-1:0]       rest_head;
    logic                restore_c;
    logic                need_sum;
    logic                taken_c;
    logic                do_push;
    logic                push_bit;
    logic                train_c;
    logic signed [SW-1:0] sum_c;
    logic signed [CMPW-1:0] sum_ext;
    logic [CMPW-1:0]     sum_abs;

    assign clearing  = clr_reg;
    assign fq_pop    = (st_reg == S_IDLE) && !clr_reg && !fq_empty && rq_space;
    assign hist_cur  = hist_reg[tidx_reg];
    assign head_cur  = head_reg[tidx_reg];
    assign head_inc  = (head_cur == HW'(HL - 1)) ? '0 : head_cur + 1'b1;
    assign rest_head = HW'(32'(it_reg.ckpt_head) % HL);
    assign restore_c = (it_reg.op == OP_SQUASH) ||
                       ((it_reg.op == OP_UPDATE) && it_reg.was_mispredicted);
    assign need_sum  = (it_reg.op == OP_LOOKUP) || (it_reg.op == OP_UPDATE);
    assign taken_c   = (it_reg.op == OP_UNCOND) ? 1'b1 : !sum_reg[SW-1];
    assign do_push   = (it_reg.op == OP_LOOKUP) || (it_reg.op == OP_UNCOND) ||
                       (it_reg.op == OP_UPDATE);
    assign push_bit  = (it_reg.op == OP_UPDATE) ? it_reg.resolved_taken : taken_c;
    assign sum_ext   = CMPW'(sum_reg);
    assign sum_abs   = sum_ext[CMPW-1] ? $unsigned(-sum_ext) : $unsigned(sum_ext);
    assign train_c   = (st_reg == S_FIN) && (it_reg.op == OP_UPDATE) &&
                       (it_reg.was_mispredicted || (sum_abs <= CMPW'(thr_reg)));

    // Weight addresses: bias at column zero, path weights at the ring entries
    // walking backward from the current head.
    always_comb
    begin
        logic [31:0]   slot_w;
        logic [HW-1:0] slot;
        logic [CB-1:0] col;
        raddr_c[0] = AW'(32'(row_reg) * COLUMNS);
        for (int i = 1; i < NB; i++)
        begin
            slot_w = 32'(head_cur) + 32'(HL) - 32'(i);
            slot   = HW'((slot_w >= 32'(HL)) ? slot_w - 32'(HL) : slot_w);
            col    = CB'(32'(ring_reg[tidx_reg][slot]) % COLUMNS);
            raddr_c[i] = AW'(32'(row_reg) * COLUMNS + 32'(col));
        end
    end

    // The signed terms are summed in a balanced adder tree so that the sum is
    // only a few adder levels deep.
    always_comb
    begin
        sum_tree[NP] = SW'($signed(rdata[0]));
        for (int k = 1; k < NP; k++)
        begin
            if (k < NB)
            begin
                sum_tree[NP + k] = hbits_reg[k-1] ? SW'($signed(rdata[k]))
                                                  : -SW'($signed(rdata[k]));
            end
            else
            begin
                sum_tree[NP + k] = '0;
            end
        end
        for (int k = NP - 1; k >= 1; k--)
        begin
            sum_tree[k] = sum_tree[2*k] + sum_tree[2*k + 1];
        end
        sum_c = sum_tree[1];
    end

    always_comb
    begin
        logic up;
        for (int i = 0; i < NB; i++)
        begin
            up = (i == 0) ? it_reg.resolved_taken
                          : (hbits_reg[(i == 0) ? 0 : i-1] == it_reg.resolved_taken);
            if (up)
            begin
                nudged_c[i] = ($signed(rdata[i]) == W_MAX) ? rdata[i] : rdata[i] + 8'd1;
            end
            else
            begin
                nudged_c[i] = ($signed(rdata[i]) == W_MIN) ? rdata[i] : rdata[i] - 8'd1;
            end
            bank_we[i]    = clr_reg || train_c;
            bank_waddr[i] = clr_reg ? clr_cnt_reg : addr_reg[i];
            bank_wdata[i] = clr_reg ? 8'd0 : nudged_c[i];
        end
    end

    always_comb
    begin
        res_push = (st_reg == S_FIN);
        res_data = '0;
        if ((it_reg.op == OP_LOOKUP) || (it_reg.op == OP_UNCOND))
        begin
            res_data.taken   = taken_c;
            res_data.history = 16'(hist_cur);
            res_data.head    = 4'(head_cur);
            res_data.addr    = ring_reg[tidx_reg][head_cur];
        end
    end

    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        pwl_ram #(.W(8), .DEPTH(DEPTH)) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr[b]),
            .wdata (bank_wdata[b]),
            .re    (st_reg == S_READ),
            .raddr (raddr_c[b]),
            .rdata (rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            thr_reg     <= THR_RESET;
            for (int t = 0; t < THREADS; t++)
            begin
                hist_reg[t] <= '0;
                head_reg[t] <= '0;
                for (int j = 0; j < HL; j++)
                begin
                    ring_reg[t][j] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (fq_pop)
                    begin
                        st_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (restore_c)
                    begin
                        hist_reg[tidx_reg]            <= HL'(it_reg.ckpt_history);
                        head_reg[tidx_reg]            <= rest_head;
                        ring_reg[tidx_reg][rest_head] <= it_reg.ckpt_addr;
                    end
                    st_reg <= need_sum ? S_READ : S_FIN;
                end
                S_READ:
                begin
                    st_reg <= S_SUM;
                end
                S_SUM:
                begin
                    st_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (do_push)
                    begin
                        hist_reg[tidx_reg]           <= {hist_cur[HL-2:0], push_bit};
                        ring_reg[tidx_reg][head_cur] <= it_reg.pc[7:0];
                        head_reg[tidx_reg]           <= head_inc;
                    end
                    if (it_reg.op == OP_CLEAR)
                    begin
                        hist_reg[tidx_reg][0] <= 1'b0;
                    end
                    st_reg <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fq_pop)
        begin
            it_reg   <= fq_item;
            tidx_reg <= TW'(fq_item.thread);
            row_reg  <= RB'(fq_item.pc % ROWS);
        end
        if (st_reg == S_READ)
        begin
            for (int i = 0; i < NB; i++)
            begin
                addr_reg[i] <= raddr_c[i];
            end
            hbits_reg <= hist_cur;
        end
        if (st_reg == S_SUM)
        begin
            sum_reg <= sum_c;
        end
    end

`ifndef SYNTH
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> (st_reg == S_IDLE))
        else $error("item started during weight clearing");
    a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
        fq_pop |=> (st_reg == S_LOAD))
        else $error("popped item not loaded");
    a_res_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> rq_space)
        else $error("result pushed into full queue");
    a_no_train_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        train_c |-> !clr_reg && (it_reg.op == OP_UPDATE))
        else $error("training outside an update");
`endif

endmodule
`default_nettype wire

// ===== sv/piecewise_linear_branch_predictor_core.sv =====
// A lookup or update goes from acceptance through load, weight read, sum and
// finish to a result in the output queue; other kinds go from load to finish.
// The single-item sequencer around the registered read and write-back of the
// weight banks takes a new transaction only once the last one has finished.
// Reset: asynchronous, active low. After reset the weight banks are cleared
// one address per cycle over all ROWS*COLUMNS addresses while full stays high.
`default_nettype none
module piecewise_linear_branch_predictor_core #(
    parameter int ROWS        = pwl_pkg::DEF_ROWS,
    parameter int COLUMNS     = pwl_pkg::DEF_COLUMNS,
    parameter int HISTORY_LEN = pwl_pkg::DEF_HISTORY_LEN,
    parameter int THREADS     = pwl_pkg::DEF_THREADS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  kind,
    input  wire logic [1:0]  thread,
    input  wire logic [31:0] pc,
    input  wire logic        resolved_taken,
    input  wire logic        was_mispredicted,
    input  wire logic [15:0] ckpt_history_in,
    input  wire logic [3:0]  ckpt_head_in,
    input  wire logic [7:0]  ckpt_addr_in,
    output logic             empty,
    input  wire logic        pop,
    output logic             predict_taken,
    output logic [15:0]      ckpt_history_out,
    output logic [3:0]       ckpt_head_out,
    output logic [7:0]       ckpt_addr_out
);
    import pwl_pkg::*;

    // The front decodes each incoming transaction into an operation and queues
    // it; the back owns the per-thread history, the path rings and the weight
    // banks, and handles one queued operation at a time.
    logic   fq_full;
    logic   fq_empty;
    logic   fq_pop;
    item_t  fq_item;
    logic   clearing;
    logic   res_push;
    res_t   res_data;
    logic   rq_full;
    logic   [$bits(res_t)-1:0] rq_dout;
    res_t   rq_item;

    // No new transaction is taken while the weight banks are being cleared.
    assign full = fq_full || clearing;

    pwl_front #(.THREADS(THREADS)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push && !full),
        .kind             (kind),
        .thread           (thread),
        .pc               (pc),
        .resolved_taken   (resolved_taken),
        .was_mispredicted (was_mispredicted),
        .ckpt_history_in  (ckpt_history_in),
        .ckpt_head_in     (ckpt_head_in),
        .ckpt_addr_in     (ckpt_addr_in),
        .full             (fq_full),
        .pop              (fq_pop),
        .item             (fq_item),
        .empty            (fq_empty)
    );

    pwl_back #(
        .ROWS        (ROWS),
        .COLUMNS     (COLUMNS),
        .HISTORY_LEN (HISTORY_LEN),
        .THREADS     (THREADS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fq_empty  (fq_empty),
        .fq_item   (fq_item),
        .fq_pop    (fq_pop),
        .rq_space  (!rq_full),
        .res_push  (res_push),
        .res_data  (res_data),
        .clearing  (clearing)
    );

    // Results wait here so the back can move on while the consumer stalls.
    pwl_fifo #(.W($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_data),
        .full  (rq_full),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty)
    );

    assign rq_item          = res_t'(rq_dout);
    assign predict_taken    = rq_item.taken;
    assign ckpt_history_out = rq_item.history;
    assign ckpt_head_out    = rq_item.head;
    assign ckpt_addr_out    = rq_item.addr;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwl_pkg::*;

    // One branch transaction as the testbench sees it. The kind is kept as a raw
    // 3-bit code so that the unused codes above the clear command can be sent.
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  thread;
        logic [31:0] pc;
        logic        resolved_taken;
        logic        was_mispredicted;
        logic [15:0] ckpt_history;
        logic [3:0]  ckpt_head;
        logic [7:0]  ckpt_addr;
    } branch_t;

    // A row of the directed table. Where the outcome is obvious, it is typed in
    // and used instead of the predictor's answer.
    typedef struct packed {
        branch_t br;
        logic    typed;
        res_t    outcome;
    } dir_row_t;

    localparam int NUM_THREADS = DEF_THREADS;
    localparam int HIST        = DEF_HISTORY_LEN;
    localparam int NUM_COLS    = DEF_COLUMNS;
    localparam int NUM_POS     = HIST + 1;
    localparam int WATCHDOG    = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 5;
    localparam int DRAIN_WAIT  = 20;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_wdata;
    logic        push;
    logic        full;
    logic [2:0]  kind;
    logic [1:0]  thread;
    logic [31:0] pc;
    logic        resolved_taken;
    logic        was_mispredicted;
    logic [15:0] ckpt_history_in;
    logic [3:0]  ckpt_head_in;
    logic [7:0]  ckpt_addr_in;
    logic        empty;
    logic        pop;
    logic        predict_taken;
    logic [15:0] ckpt_history_out;
    logic [3:0]  ckpt_head_out;
    logic [7:0]  ckpt_addr_out;

    piecewise_linear_branch_predictor_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .push             (push),
        .full             (full),
        .kind             (kind),
        .thread           (thread),
        .pc               (pc),
        .resolved_taken   (resolved_taken),
        .was_mispredicted (was_mispredicted),
        .ckpt_history_in  (ckpt_history_in),
        .ckpt_head_in     (ckpt_head_in),
        .ckpt_addr_in     (ckpt_addr_in),
        .empty            (empty),
        .pop              (pop),
        .predict_taken    (predict_taken),
        .ckpt_history_out (ckpt_history_out),
        .ckpt_head_out    (ckpt_head_out),
        .ckpt_addr_out    (ckpt_addr_out)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the per-thread path history and of
    // the shared weight table. The table is large and mostly untouched, so it
    // is kept sparse; an entry that was never trained reads as zero.
    // ------------------------------------------------------------------
    logic [11:0]     train_bound;
    logic [15:0]     outcome_hist [NUM_THREADS];
    logic [3:0]      ring_head    [NUM_THREADS];
    logic [7:0]      ring_addr    [NUM_THREADS][HIST];
    byte             weight_tab   [int];
    res_t            last_ckpt    [NUM_THREADS];
    res_t            pending_results [$];

    int  errors;
    int  mismatches;
    int  sent_count;
    int  popped_count;
    int  trained_count;
    int  idle_cycles;
    int  burst_left;
    bit  hold_request;

    function automatic int weight_index(int row, int col, int position);
        return (row * NUM_COLS + col) * NUM_POS + position;
    endfunction

    function automatic int read_weight(int idx);
        if (weight_tab.exists(idx))
            return weight_tab[idx];
        return 0;
    endfunction

    // Saturating step of one weight toward +127 or -128.
    function automatic void nudge_weight(int idx, bit up);
        int v;
        v = read_weight(idx);
        if (up && v < 127)
            v++;
        else if (!up && v > -128)
            v--;
        weight_tab[idx] = byte'(v);
    endfunction

    // Path column for history position i: the ring entry i steps behind the
    // head. Position HIST wraps around onto the head slot itself.
    function automatic int path_column(int t, int i);
        logic [3:0] slot;
        slot = ring_head[t] - 4'(i);
        return ring_addr[t][slot];
    endfunction

    function automatic int path_sum(int t, int row);
        int s;
        int w;
        s = read_weight(weight_index(row, 0, 0));
        for (int i = 1; i <= HIST; i++) begin
            w = read_weight(weight_index(row, path_column(t, i), i));
            if (outcome_hist[t][i-1])
                s += w;
            else
                s -= w;
        end
        return s;
    endfunction

    function automatic void shift_in(int t, logic [31:0] addr, bit taken);
        outcome_hist[t] = {outcome_hist[t][14:0], taken};
        ring_addr[t][ring_head[t]] = addr[7:0];
        ring_head[t] = ring_head[t] + 4'd1;
    endfunction

    function automatic void rewind(int t, branch_t br);
        outcome_hist[t] = br.ckpt_history;
        ring_head[t] = br.ckpt_head;
        ring_addr[t][br.ckpt_head] = br.ckpt_addr;
    endfunction

    // Works out the result of one accepted transaction and advances the
    // predictor state exactly as the block is expected to.
    function automatic res_t predict_branch(branch_t br);
        res_t r;
        int   t;
        int   row;
        int   s;
        bit   taken;
        r = '0;
        t = br.thread;
        row = br.pc[7:0];
        case (br.kind)
            KIND_LOOKUP, KIND_UNCOND: begin
                taken = 1'b1;
                if (br.kind == KIND_LOOKUP)
                    taken = path_sum(t, row) >= 0;
                r.taken = taken;
                r.history = outcome_hist[t];
                r.head = ring_head[t];
                r.addr = ring_addr[t][ring_head[t]];
                last_ckpt[t] = r;
                shift_in(t, br.pc, taken);
            end
            KIND_UPDATE: begin
                if (br.was_mispredicted)
                    rewind(t, br);
                s = path_sum(t, row);
                if (s < 0)
                    s = -s;
                if (br.was_mispredicted || s <= int'(train_bound)) begin
                    trained_count++;
                    nudge_weight(weight_index(row, 0, 0), br.resolved_taken);
                    for (int i = 1; i <= HIST; i++)
                        nudge_weight(weight_index(row, path_column(t, i), i),
                                     outcome_hist[t][i-1] == br.resolved_taken);
                end
                shift_in(t, br.pc, br.resolved_taken);
            end
            KIND_SQUASH: rewind(t, br);
            KIND_CLEAR:  outcome_hist[t][0] = 1'b0;
            default: ;
        endcase
        return r;
    endfunction

    // Random transaction. Most traffic is well-formed: lookups on a small set
    // of rows so the weights really train, updates that replay a checkpoint
    // the block actually handed out, and squashes back to such checkpoints.
    // A minority carries random checkpoints, full random addresses or
    // unused kind codes.
    function automatic branch_t random_branch();
        branch_t br;
        int      sel;
        int      t;
        br = '0;
        t = $urandom_range(0, NUM_THREADS - 1);
        br.thread = t;
        if ($urandom_range(0, 9) == 0)
            br.pc = $urandom;
        else
            br.pc = ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(0, 11));
        br.resolved_taken = $urandom_range(0, 1);
        sel = $urandom_range(0, 99);
        if (sel < 38)
            br.kind = KIND_LOOKUP;
        else if (sel < 46)
            br.kind = KIND_UNCOND;
        else if (sel < 80)
            br.kind = KIND_UPDATE;
        else if (sel < 88)
            br.kind = KIND_SQUASH;
        else if (sel < 94)
            br.kind = KIND_CLEAR;
        else
            br.kind = 3'($urandom_range(5, 7));
        br.was_mispredicted = $urandom_range(0, 2) == 0;
        if ($urandom_range(0, 4) == 0) begin
            br.ckpt_history = $urandom;
            br.ckpt_head = $urandom;
            br.ckpt_addr = $urandom;
        end else begin
            br.ckpt_history = last_ckpt[t].history;
            br.ckpt_head = last_ckpt[t].head;
            br.ckpt_addr = last_ckpt[t].addr;
        end
        return br;
    endfunction

    // Clock: 2 ns period.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Results side. Pop is driven on the falling edge in segments of random
    // length: always ready, coin-flip, or mostly stalled. On request it holds
    // off for a long stretch so that the block backs up into its input.
    initial begin
        int seg_left;
        int seg_mode;
        int hold_left;
        seg_left = 0;
        seg_mode = 0;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(5, 40);
                    seg_mode = $urandom_range(0, 2);
                end
                seg_left--;
                case (seg_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= $urandom_range(0, 4) == 0;
                endcase
            end
        end
    end

    // Result checking against the oldest pending expectation, field by field.
    always @(posedge clk) begin
        res_t want;
        if (rst_n && pop && !empty) begin
            popped_count++;
            if (pending_results.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result transaction with nothing expected", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (predict_taken !== want.taken || ckpt_history_out !== want.history ||
                    ckpt_head_out !== want.head || ckpt_addr_out !== want.addr) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch: expected taken=%0b hist=%h head=%h addr=%h, got taken=%0b hist=%h head=%h addr=%h",
                                 $realtime, want.taken, want.history, want.head, want.addr,
                                 predict_taken, ckpt_history_out, ckpt_head_out,
                                 ckpt_addr_out);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    // The limit covers the weight clearing pass after reset with room to spare.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one transaction from the falling edge until it is accepted,
    // with a random gap in two of three cases when the current burst runs out.
    task automatic send_branch(branch_t br, logic typed, res_t outcome);
        res_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        burst_left--;
        push             <= 1'b1;
        kind             <= br.kind;
        thread           <= br.thread;
        pc               <= br.pc;
        resolved_taken   <= br.resolved_taken;
        was_mispredicted <= br.was_mispredicted;
        ckpt_history_in  <= br.ckpt_history;
        ckpt_head_in     <= br.ckpt_head;
        ckpt_addr_in     <= br.ckpt_addr;
        do
            @(posedge clk);
        while (full);
        r = predict_branch(br);
        pending_results.push_back(typed ? outcome : r);
        sent_count++;
        @(negedge clk);
    endtask

    // Waits until every expected result has been popped, then lets the
    // pipeline settle so that a register write cannot overtake work in flight.
    task automatic drain_results();
        push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_bound(logic [11:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        train_bound = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Directed table: reset state, both address extremes, every kind including
    // the unused codes, a restoring update with an all-ones checkpoint, a
    // squash, and the history clear on a btb miss.
    dir_row_t directed [] = '{
        '{'{KIND_LOOKUP, 2'd0, 32'h0000_0000, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b1, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_UNCOND, 2'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b1, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_LOOKUP, 2'd1, 32'h0000_0100, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b1, 16'h0001, 4'h1, 8'h00}},
        '{'{KIND_UPDATE, 2'd0, 32'h0000_0000, 1'b0, 1'b1, 16'hFFFF, 4'hF, 8'hFF},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_SQUASH, 2'd2, 32'h0000_0000, 1'b0, 1'b0, 16'hFFFF, 4'hF, 8'hFF},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_CLEAR, 2'd2, 32'h0000_0000, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_LOOKUP, 2'd2, 32'h0000_0100, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b0, '0},
        '{'{3'd5, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 4'hF, 8'hFF},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{3'd6, 2'd3, 32'h0000_0000, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{3'd7, 2'd3, 32'h1234_5678, 1'b1, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_UPDATE, 2'd3, 32'h0000_0000, 1'b1, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_LOOKUP, 2'd3, 32'h0000_0000, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b0, '0},
        '{'{KIND_UPDATE, 2'd3, 32'hFFFF_FF00, 1'b0, 1'b1, 16'hA5A5, 4'h0, 8'h5A},
          1'b1, '{1'b0, 16'h0000, 4'h0, 8'h00}},
        '{'{KIND_LOOKUP, 2'd3, 32'h8000_0000, 1'b0, 1'b0, 16'h0, 4'h0, 8'h00},
          1'b0, '0}
    };

    // Main sequence: reset, wait out the weight clearing pass, directed table,
    // then random phases under different training bounds with both extremes.
    initial begin
        logic [11:0] bounds [NUM_PHASES];
        errors = 0;
        mismatches = 0;
        sent_count = 0;
        popped_count = 0;
        trained_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_request = 1'b0;
        train_bound = THR_RESET;
        for (int t = 0; t < NUM_THREADS; t++) begin
            outcome_hist[t] = '0;
            ring_head[t] = '0;
            last_ckpt[t] = '0;
            for (int i = 0; i < HIST; i++)
                ring_addr[t][i] = '0;
        end
        bounds = '{12'd0, 12'd4095, 12'($urandom_range(1, 200)), THR_RESET, 12'd7};

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        push             = 1'b0;
        kind             = KIND_LOOKUP;
        thread           = '0;
        pc               = '0;
        resolved_taken   = 1'b0;
        was_mispredicted = 1'b0;
        ckpt_history_in  = '0;
        ckpt_head_in     = '0;
        ckpt_addr_in     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The first table runs on the reset value of the training bound.
        wait (!full);
        @(negedge clk);
        foreach (directed[n])
            send_branch(directed[n].br, directed[n].typed, directed[n].outcome);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_bound(bounds[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver stall early in the second phase.
                if (p == 1 && n == 10)
                    hold_request = 1'b1;
                // Sender stops until the block has handed back everything.
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    push <= 1'b0;
                    wait (pending_results.size() == 0);
                    @(negedge clk);
                end
                send_branch(random_branch(), 1'b0, '0);
            end
        end

        push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d branch transactions sent, %0d results checked over %0d bound settings",
                 sent_count, popped_count, NUM_PHASES + 1);
        $display("%0d updates trained the weights, %0d mismatches", trained_count, mismatches);
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
sv/pwl_pkg.sv
sv/pwl_ram.sv
sv/pwl_fifo.sv
sv/pwl_front.sv
sv/pwl_back.sv
sv/piecewise_linear_branch_predictor_core.sv
sim/tb.sv
